FILE: rtl/qpd_pkg.sv
// Shared constants and helpers for the quoted-printable decoder.
package qpd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    typedef logic [BYTE_W-1:0] byte_t;

    localparam byte_t CH_EQUALS     = 8'h3D;
    localparam byte_t CH_UNDERSCORE = 8'h5F;
    localparam byte_t CH_SPACE      = 8'h20;
    localparam byte_t CH_NUL        = 8'h00;
    localparam byte_t CH_TAB        = 8'h09;
    localparam byte_t CH_CR         = 8'h0D;
    localparam byte_t CH_MARKER     = 8'hBF;

    // Register index of header_mode (word address paddr[2])
    localparam logic REG_HEADER_MODE = 1'b0;

    // Escape tracking codes
    localparam logic [1:0] ESC_IDLE   = 2'd0;
    localparam logic [1:0] ESC_START  = 2'd1;
    localparam logic [1:0] ESC_DIGIT  = 2'd2;
    localparam logic [1:0] ESC_UNUSED = 2'd3;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } hex_t;

    function automatic hex_t hex_decode(input byte_t c);
        hex_t h;
        h.ok     = 1'b1;
        h.nibble = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.nibble = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            h.nibble = c[3:0] + 4'd9;
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_white(input byte_t c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

FILE: rtl/quoted_printable_decoder_unit.sv
// Quoted-printable decoder: one encoded byte per request, zero or one decoded byte out.
//
// Takes one encoded byte per clock and, while the output side keeps taking results, keeps
// that rate indefinitely; a byte goes through an input register and then a result register,
// which drives the outputs. A byte that yields nothing (the '=' and first digit of an escape,
// dropped whitespace or NUL) still passes through the input register. A result held by
// out_ready low stalls the input once the input register is full.
// An escape "=XY" with hex digits in either case gives one byte; otherwise 0xBF with
// bad_escape set. header_mode (APB register 0, bit 0) drops whitespace everywhere and turns a
// literal '_' into a space; with it clear a literal NUL is dropped. Write header_mode only
// while the block is idle.
module quoted_printable_decoder_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  in_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_byte,
    output logic                        bad_escape,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qpd_pkg::APB_AW-1:0]  paddr,
    input  logic [qpd_pkg::APB_DW-1:0]  pwdata,
    output logic [qpd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import qpd_pkg::*;

    logic       header_mode_reg;
    logic       in_valid_reg;
    byte_t      in_byte_reg;
    logic [1:0] esc_reg;
    logic [1:0] esc_next;
    byte_t      first_digit_reg;
    byte_t      first_digit_next;
    logic       out_valid_reg;
    byte_t      out_byte_reg;
    byte_t      out_byte_next;
    logic       bad_escape_reg;
    logic       bad_escape_next;
    logic       emit;
    logic       s1_fire;
    logic       drop_white;
    hex_t       hi_hex;
    hex_t       lo_hex;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEADER_MODE)
                  ? {{(APB_DW-1){1'b0}}, header_mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_HEADER_MODE)
        begin
            header_mode_reg <= pwdata[0];
        end
    end

    // Advance the held byte when the result slot is free or being drained
    assign s1_fire  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || s1_fire;

    assign drop_white = header_mode_reg && is_white(in_byte_reg);
    assign hi_hex     = hex_decode(first_digit_reg);
    assign lo_hex     = hex_decode(in_byte_reg);

    always_comb
    begin
        emit             = 1'b0;
        esc_next         = esc_reg;
        first_digit_next = first_digit_reg;
        out_byte_next    = in_byte_reg;
        bad_escape_next  = 1'b0;
        if (!drop_white)
        begin
            unique case (esc_reg)
                ESC_START:
                begin
                    first_digit_next = in_byte_reg;
                    esc_next         = ESC_DIGIT;
                end
                ESC_DIGIT:
                begin
                    esc_next         = ESC_IDLE;
                    first_digit_next = '0;
                    emit             = 1'b1;
                    if (hi_hex.ok && lo_hex.ok)
                    begin
                        out_byte_next = {hi_hex.nibble, lo_hex.nibble};
                    end
                    else
                    begin
                        out_byte_next   = CH_MARKER;
                        bad_escape_next = 1'b1;
                    end
                end
                default:
                begin
                    esc_next = ESC_IDLE;
                    if (in_byte_reg == CH_EQUALS)
                    begin
                        esc_next = ESC_START;
                    end
                    else if (!(!header_mode_reg && in_byte_reg == CH_NUL))
                    begin
                        emit = 1'b1;
                        if (header_mode_reg && in_byte_reg == CH_UNDERSCORE)
                        begin
                            out_byte_next = CH_SPACE;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            esc_reg         <= ESC_IDLE;
            first_digit_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                esc_reg         <= esc_next;
                first_digit_reg <= first_digit_next;
                out_valid_reg   <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
        end
        if (s1_fire && emit)
        begin
            out_byte_reg   <= out_byte_next;
            bad_escape_reg <= bad_escape_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign bad_escape = bad_escape_reg;

    a_esc_reachable: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg != ESC_UNUSED)
        else $error("escape state reached unused code");

    a_bad_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && bad_escape_reg |-> out_byte_reg == CH_MARKER)
        else $error("bad escape without marker byte");

    a_esc_start: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && esc_reg == ESC_START && !drop_white |=> esc_reg == ESC_DIGIT)
        else $error("first escape digit not captured");

endmodule
